// File: hw/rtl/gmds_pkg.sv
// ============================================================================
// gmds_pkg
// Shared types and constants of the grid maze depth-first search solver.
// ============================================================================
`default_nettype none

package gmds_pkg;

    localparam int MAX_ROWS = 8;
    localparam int MAX_COLS = 8;
    localparam int CELLS    = 64;
    localparam int CELL_W   = 6;
    localparam int ROW_W    = 3;
    localparam int COL_W    = 3;
    localparam int DEPTH_W  = 7;
    localparam int SIDE_W   = 3;
    localparam int DIM_W    = 4;

    localparam logic [1:0] CMD_CLEAR = 2'd0;
    localparam logic [1:0] CMD_ADD   = 2'd1;
    localparam logic [1:0] CMD_SOLVE = 2'd2;

    localparam logic [1:0] SIDE_UP    = 2'd0;
    localparam logic [1:0] SIDE_LEFT  = 2'd1;
    localparam logic [1:0] SIDE_DOWN  = 2'd2;
    localparam logic [1:0] SIDE_RIGHT = 2'd3;

    localparam logic CFG_ROWS = 1'b0;
    localparam logic CFG_COLS = 1'b1;

    typedef struct packed {
        logic load_item;
        logic div_step;
        logic wall_clear;
        logic wall_rd;
        logic wall_wr_cell;
        logic wall_wr_nb;
        logic solve_init;
        logic dfs_step;
        logic pop;
        logic load_top;
        logic emit_rd;
        logic emit_out;
        logic emit_top;
        logic emit_fail;
    } gmds_ctl_t;

    typedef struct packed {
        logic div_done;
        logic in_grid;
        logic goal_ok;
        logic nb_ok;
        logic at_goal;
        logic side_done;
        logic depth_one;
        logic emit_more;
    } gmds_sts_t;

endpackage

`default_nettype wire

// File: hw/rtl/grid_maze_dfs_solver.sv
// ============================================================================
// grid_maze_dfs_solver
// Depth-first search maze solver over a grid of up to 8 x 8 cells.
// ============================================================================
// A command is taken at a clock edge with start high and busy low. Clear
// (command 0) empties the wall map at that edge and never raises busy; add
// wall (command 1) holds busy through a row split by repeated subtraction,
// then a read-modify-write of the cell and, if it lies in the grid, of its
// neighbor in the wall memory; a cell outside the grid writes nothing. Solve
// (command 2) takes the split, a setup step, a search step per side tried,
// a stack pop and a reload of the top per backtrack, and a stack read and
// an output per path beat; the wall and stack memories have registered
// reads. One command runs at a time. Results come out as beats on
// path_cell/found/last marked by result_valid, one cycle each; the final
// beat shows in the first idle cycle. The receiver cannot stall, so every
// beat must be taken when shown. A failed search, or a solve with a start
// or goal cell outside the grid, gives one beat with found low and last high.
// Grid size is written on cfg_write/cfg_index/cfg_data while idle.
// Reset clears the wall map, sets an 8 x 8 grid and returns to idle.
// ============================================================================
`default_nettype none

module grid_maze_dfs_solver
    import gmds_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    output logic              busy,
    input  logic [1:0]        command,
    input  logic [CELL_W-1:0] wall_cell,
    input  logic [1:0]        wall_side,
    input  logic [CELL_W-1:0] start_cell,
    input  logic [CELL_W-1:0] goal_cell,
    input  logic              cfg_write,
    input  logic              cfg_index,
    input  logic [DIM_W-1:0]  cfg_data,
    output logic              result_valid,
    output logic [CELL_W-1:0] path_cell,
    output logic              found,
    output logic              last
);

    gmds_ctl_t ctl;
    gmds_sts_t sts;

    gmds_ctrl u_ctrl (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (start),
        .command (command),
        .sts     (sts),
        .ctl     (ctl),
        .busy    (busy)
    );

    gmds_datapath u_datapath (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_write    (cfg_write),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .command      (command),
        .wall_cell    (wall_cell),
        .wall_side    (wall_side),
        .start_cell   (start_cell),
        .goal_cell    (goal_cell),
        .ctl          (ctl),
        .sts          (sts),
        .result_valid (result_valid),
        .path_cell    (path_cell),
        .found        (found),
        .last         (last)
    );

`ifndef SYNTHESIS
    a_mid_path_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && !last) |-> busy)
        else $error("non-final path beat shown while idle");

    a_fail_shape: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && !found) |-> (last && (path_cell == '0)))
        else $error("no-path beat not final or cell not zero");

    a_solve_starts: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && (command == CMD_SOLVE)) |=> busy)
        else $error("solve command taken without going busy");
`endif

endmodule

`default_nettype wire

// File: hw/rtl/gmds_ctrl.sv
// ============================================================================
// gmds_ctrl
// Command sequencer: wall clears and updates, search steps, backtracking, path output.
// ============================================================================
`default_nettype none

module gmds_ctrl
    import gmds_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       start,
    input  logic [1:0] command,
    input  gmds_sts_t  sts,
    output gmds_ctl_t  ctl,
    output logic       busy
);

    localparam logic [3:0] ST_IDLE      = 4'd0;
    localparam logic [3:0] ST_DIV       = 4'd1;
    localparam logic [3:0] ST_WALL_RD   = 4'd2;
    localparam logic [3:0] ST_WALL_WR   = 4'd3;
    localparam logic [3:0] ST_WALL_NB   = 4'd4;
    localparam logic [3:0] ST_INIT      = 4'd5;
    localparam logic [3:0] ST_CHECK     = 4'd6;
    localparam logic [3:0] ST_POP       = 4'd7;
    localparam logic [3:0] ST_LOAD      = 4'd8;
    localparam logic [3:0] ST_EMIT_ADDR = 4'd9;
    localparam logic [3:0] ST_EMIT_OUT  = 4'd10;
    localparam logic [3:0] ST_EMIT_TOP  = 4'd11;
    localparam logic [3:0] ST_EMIT_FAIL = 4'd12;

    logic [3:0] state_reg;
    logic [3:0] state_next;
    logic       solve_reg;
    logic       solve_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            solve_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            solve_reg <= solve_next;
        end
    end

    always_comb
    begin
        ctl        = '0;
        state_next = state_reg;
        solve_next = solve_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    case (command)
                        CMD_CLEAR:
                        begin
                            ctl.wall_clear = 1'b1;
                        end
                        CMD_ADD:
                        begin
                            ctl.load_item = 1'b1;
                            solve_next    = 1'b0;
                            state_next    = ST_DIV;
                        end
                        CMD_SOLVE:
                        begin
                            ctl.load_item = 1'b1;
                            solve_next    = 1'b1;
                            state_next    = ST_DIV;
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            ST_DIV:
            begin
                if (solve_reg && !(sts.in_grid && sts.goal_ok))
                begin
                    state_next = ST_EMIT_FAIL;
                end
                else if (!sts.in_grid)
                begin
                    state_next = ST_IDLE;
                end
                else if (sts.div_done)
                begin
                    state_next = solve_reg ? ST_INIT : ST_WALL_RD;
                end
                else
                begin
                    ctl.div_step = 1'b1;
                end
            end
            ST_WALL_RD:
            begin
                ctl.wall_rd = 1'b1;
                state_next  = ST_WALL_WR;
            end
            ST_WALL_WR:
            begin
                ctl.wall_wr_cell = 1'b1;
                state_next       = sts.nb_ok ? ST_WALL_NB : ST_IDLE;
            end
            ST_WALL_NB:
            begin
                ctl.wall_wr_nb = 1'b1;
                state_next     = ST_IDLE;
            end
            ST_INIT:
            begin
                ctl.solve_init = 1'b1;
                state_next     = ST_CHECK;
            end
            ST_CHECK:
            begin
                if (sts.at_goal)
                begin
                    state_next = sts.depth_one ? ST_EMIT_TOP : ST_EMIT_ADDR;
                end
                else if (sts.side_done)
                begin
                    state_next = sts.depth_one ? ST_EMIT_FAIL : ST_POP;
                end
                else
                begin
                    ctl.dfs_step = 1'b1;
                end
            end
            ST_POP:
            begin
                ctl.pop    = 1'b1;
                state_next = ST_LOAD;
            end
            ST_LOAD:
            begin
                ctl.load_top = 1'b1;
                state_next   = ST_CHECK;
            end
            ST_EMIT_ADDR:
            begin
                ctl.emit_rd = 1'b1;
                state_next  = ST_EMIT_OUT;
            end
            ST_EMIT_OUT:
            begin
                ctl.emit_out = 1'b1;
                state_next   = sts.emit_more ? ST_EMIT_ADDR : ST_EMIT_TOP;
            end
            ST_EMIT_TOP:
            begin
                ctl.emit_top = 1'b1;
                state_next   = ST_IDLE;
            end
            ST_EMIT_FAIL:
            begin
                ctl.emit_fail = 1'b1;
                state_next    = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign busy = (state_reg != ST_IDLE);

endmodule

`default_nettype wire

// File: hw/rtl/gmds_datapath.sv
// ============================================================================
// gmds_datapath
// Wall map, visited marks, search stack, grid size and result registers.
// ============================================================================
`default_nettype none

module gmds_datapath
    import gmds_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              cfg_write,
    input  logic              cfg_index,
    input  logic [DIM_W-1:0]  cfg_data,
    input  logic [1:0]        command,
    input  logic [CELL_W-1:0] wall_cell,
    input  logic [1:0]        wall_side,
    input  logic [CELL_W-1:0] start_cell,
    input  logic [CELL_W-1:0] goal_cell,
    input  gmds_ctl_t         ctl,
    output gmds_sts_t         sts,
    output logic              result_valid,
    output logic [CELL_W-1:0] path_cell,
    output logic              found,
    output logic              last
);

    typedef struct packed {
        logic              ok;
        logic [CELL_W-1:0] cell_id;
        logic [ROW_W-1:0]  row;
        logic [COL_W-1:0]  col;
    } nb_t;

    typedef struct packed {
        logic [CELL_W-1:0] cell_id;
        logic [ROW_W-1:0]  row;
        logic [COL_W-1:0]  col;
        logic [SIDE_W-1:0] side;
    } stk_t;

    function automatic nb_t nb_of(
        input logic [CELL_W-1:0] cell_id,
        input logic [ROW_W-1:0]  row,
        input logic [COL_W-1:0]  col,
        input logic [1:0]        side,
        input logic [DIM_W-1:0]  rows,
        input logic [DIM_W-1:0]  cols
    );
        nb_t n;
        n.ok      = 1'b0;
        n.cell_id = cell_id;
        n.row     = row;
        n.col     = col;
        case (side)
            SIDE_UP:
            begin
                n.ok      = (row != '0);
                n.cell_id = cell_id - {2'b00, cols};
                n.row     = row - 1'b1;
            end
            SIDE_LEFT:
            begin
                n.ok      = (col != '0);
                n.cell_id = cell_id - 1'b1;
                n.col     = col - 1'b1;
            end
            SIDE_DOWN:
            begin
                n.ok      = (({1'b0, row} + 4'd1) < rows);
                n.cell_id = cell_id + {2'b00, cols};
                n.row     = row + 1'b1;
            end
            SIDE_RIGHT:
            begin
                n.ok      = (({1'b0, col} + 4'd1) < cols);
                n.cell_id = cell_id + 1'b1;
                n.col     = col + 1'b1;
            end
            default:
            begin
            end
        endcase
        return n;
    endfunction

    // grid size
    logic [DIM_W-1:0]   grid_rows_reg;
    logic [DIM_W-1:0]   grid_cols_reg;
    logic [DIM_W-1:0]   rows_eff;
    logic [DIM_W-1:0]   cols_eff;
    logic [DEPTH_W-1:0] ncells;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            grid_rows_reg <= DIM_W'(MAX_ROWS);
            grid_cols_reg <= DIM_W'(MAX_COLS);
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                CFG_ROWS: grid_rows_reg <= cfg_data;
                CFG_COLS: grid_cols_reg <= cfg_data;
                default:  grid_rows_reg <= grid_rows_reg;
            endcase
        end
    end

    always_comb
    begin
        rows_eff = (grid_rows_reg == '0) ? DIM_W'(1)
                 : (grid_rows_reg > DIM_W'(MAX_ROWS)) ? DIM_W'(MAX_ROWS) : grid_rows_reg;
        cols_eff = (grid_cols_reg == '0) ? DIM_W'(1)
                 : (grid_cols_reg > DIM_W'(MAX_COLS)) ? DIM_W'(MAX_COLS) : grid_cols_reg;
        ncells   = {3'b000, rows_eff} * {3'b000, cols_eff};
    end

    // item capture and row/column split by repeated subtraction
    logic [CELL_W-1:0] cur_reg;
    logic [CELL_W-1:0] rem_reg;
    logic [ROW_W-1:0]  row_reg;
    logic [1:0]        side_in_reg;
    logic [CELL_W-1:0] goal_reg;

    always_ff @(posedge clk)
    begin
        if (ctl.load_item)
        begin
            cur_reg     <= (command == CMD_SOLVE) ? start_cell : wall_cell;
            rem_reg     <= (command == CMD_SOLVE) ? start_cell : wall_cell;
            row_reg     <= '0;
            side_in_reg <= wall_side;
            goal_reg    <= goal_cell;
        end
        else if (ctl.div_step)
        begin
            rem_reg <= rem_reg - {2'b00, cols_eff};
            row_reg <= row_reg + 1'b1;
        end
    end

    // search top of stack
    logic [CELL_W-1:0]  top_cell_reg;
    logic [ROW_W-1:0]   top_row_reg;
    logic [COL_W-1:0]   top_col_reg;
    logic [SIDE_W-1:0]  top_side_reg;
    logic [DEPTH_W-1:0] depth_reg;
    logic [CELL_W-1:0]  emit_idx_reg;
    logic [CELLS-1:0]   visited_reg;

    nb_t nb_wall;
    nb_t nb_top;
    logic [3:0] wall_eff;
    logic       push_ok;

    // wall map memory with per-entry valid bits
    logic [3:0]        wall_mem [CELLS];
    logic [CELLS-1:0]  wall_vld_reg;
    logic [3:0]        wall_rd_reg;
    logic              wall_rd_vld_reg;
    logic              wall_we;
    logic [CELL_W-1:0] wall_wr_addr;
    logic [3:0]        wall_wr_data;
    logic              wall_re;
    logic [CELL_W-1:0] wall_rd_addr;

    // search stack memory
    stk_t              stk_mem [CELLS];
    stk_t              stk_rd_reg;
    stk_t              stk_wr_data;
    logic              stk_we;
    logic [CELL_W-1:0] stk_wr_addr;
    logic              stk_re;
    logic [CELL_W-1:0] stk_rd_addr;

    always_comb
    begin
        nb_wall  = nb_of(cur_reg, row_reg, rem_reg[COL_W-1:0], side_in_reg, rows_eff, cols_eff);
        nb_top   = nb_of(top_cell_reg, top_row_reg, top_col_reg, top_side_reg[1:0],
                         rows_eff, cols_eff);
        wall_eff = wall_rd_vld_reg ? wall_rd_reg : 4'b0000;
        push_ok  = !wall_eff[top_side_reg[1:0]] && nb_top.ok && !visited_reg[nb_top.cell_id]
                 && (depth_reg < DEPTH_W'(CELLS));

        wall_we      = ctl.wall_wr_cell || ctl.wall_wr_nb;
        wall_wr_addr = ctl.wall_wr_cell ? cur_reg : nb_wall.cell_id;
        wall_wr_data = ctl.wall_wr_cell ? (wall_eff | (4'b0001 << side_in_reg))
                                        : (wall_eff | (4'b0001 << (side_in_reg + 2'd2)));
        wall_re      = ctl.wall_rd || ctl.solve_init || ctl.load_top
                     || (ctl.dfs_step && push_ok) || (ctl.wall_wr_cell && nb_wall.ok);
        if (ctl.load_top)
            wall_rd_addr = stk_rd_reg.cell_id;
        else if (ctl.dfs_step)
            wall_rd_addr = nb_top.cell_id;
        else if (ctl.wall_wr_cell)
            wall_rd_addr = nb_wall.cell_id;
        else
            wall_rd_addr = cur_reg;

        stk_we              = ctl.dfs_step && push_ok;
        stk_wr_addr         = CELL_W'(depth_reg - 7'd1);
        stk_wr_data.cell_id = top_cell_reg;
        stk_wr_data.row     = top_row_reg;
        stk_wr_data.col     = top_col_reg;
        stk_wr_data.side    = top_side_reg + 1'b1;
        stk_re              = ctl.pop || ctl.emit_rd;
        stk_rd_addr         = ctl.pop ? CELL_W'(depth_reg - 7'd2) : emit_idx_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            wall_vld_reg <= '0;
        else if (ctl.wall_clear)
            wall_vld_reg <= '0;
        else if (wall_we)
            wall_vld_reg[wall_wr_addr] <= 1'b1;
    end

    always_ff @(posedge clk)
    begin
        if (wall_we)
            wall_mem[wall_wr_addr] <= wall_wr_data;
        if (wall_re)
        begin
            wall_rd_reg     <= wall_mem[wall_rd_addr];
            wall_rd_vld_reg <= wall_vld_reg[wall_rd_addr];
        end
    end

    always_ff @(posedge clk)
    begin
        if (stk_we)
            stk_mem[stk_wr_addr] <= stk_wr_data;
        if (stk_re)
            stk_rd_reg <= stk_mem[stk_rd_addr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            depth_reg    <= '0;
            emit_idx_reg <= '0;
            visited_reg  <= '0;
        end
        else if (ctl.solve_init)
        begin
            depth_reg    <= DEPTH_W'(1);
            emit_idx_reg <= '0;
            visited_reg  <= CELLS'(1) << cur_reg;
        end
        else if (ctl.dfs_step && push_ok)
        begin
            depth_reg                   <= depth_reg + 1'b1;
            visited_reg[nb_top.cell_id] <= 1'b1;
        end
        else if (ctl.pop)
        begin
            depth_reg <= depth_reg - 1'b1;
        end
        else if (ctl.emit_out)
        begin
            emit_idx_reg <= emit_idx_reg + 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.solve_init)
        begin
            top_cell_reg <= cur_reg;
            top_row_reg  <= row_reg;
            top_col_reg  <= rem_reg[COL_W-1:0];
            top_side_reg <= '0;
        end
        else if (ctl.dfs_step)
        begin
            if (push_ok)
            begin
                top_cell_reg <= nb_top.cell_id;
                top_row_reg  <= nb_top.row;
                top_col_reg  <= nb_top.col;
                top_side_reg <= '0;
            end
            else
            begin
                top_side_reg <= top_side_reg + 1'b1;
            end
        end
        else if (ctl.load_top)
        begin
            top_cell_reg <= stk_rd_reg.cell_id;
            top_row_reg  <= stk_rd_reg.row;
            top_col_reg  <= stk_rd_reg.col;
            top_side_reg <= stk_rd_reg.side;
        end
    end

    // result registers
    logic              result_valid_reg;
    logic [CELL_W-1:0] path_cell_reg;
    logic              found_reg;
    logic              last_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            result_valid_reg <= 1'b0;
        else
            result_valid_reg <= ctl.emit_out || ctl.emit_top || ctl.emit_fail;
    end

    always_ff @(posedge clk)
    begin
        if (ctl.emit_out)
        begin
            path_cell_reg <= stk_rd_reg.cell_id;
            found_reg     <= 1'b1;
            last_reg      <= 1'b0;
        end
        else if (ctl.emit_top)
        begin
            path_cell_reg <= top_cell_reg;
            found_reg     <= 1'b1;
            last_reg      <= 1'b1;
        end
        else if (ctl.emit_fail)
        begin
            path_cell_reg <= '0;
            found_reg     <= 1'b0;
            last_reg      <= 1'b1;
        end
    end

    assign result_valid = result_valid_reg;
    assign path_cell    = path_cell_reg;
    assign found        = found_reg;
    assign last         = last_reg;

    always_comb
    begin
        sts.div_done  = (rem_reg < {2'b00, cols_eff});
        sts.in_grid   = ({1'b0, cur_reg} < ncells);
        sts.goal_ok   = ({1'b0, goal_reg} < ncells);
        sts.nb_ok     = nb_wall.ok;
        sts.at_goal   = (top_cell_reg == goal_reg);
        sts.side_done = top_side_reg[2];
        sts.depth_one = (depth_reg == DEPTH_W'(1));
        sts.emit_more = (({1'b0, emit_idx_reg} + 7'd2) < depth_reg);
    end

endmodule

`default_nettype wire

// File: tb/testbench.sv
// ============================================================================
// testbench
// Self-checking bench for grid_maze_dfs_solver: a scoreboard class keeps its
// own wall map and grid size, runs the depth-first search for every solve
// taken and queues the path beats; each result beat is checked against the
// oldest queued beat. Directed mazes come first, then random mazes across
// several grid sizes, with the sender working in random bursts.
// ============================================================================

module testbench;
    import gmds_pkg::*;

    localparam logic [1:0] CMD_NONE = 2'd3;

    typedef struct packed {
        logic [CELL_W-1:0] cell_id;
        logic              found;
        logic              last;
    } path_beat_t;

    class path_scoreboard;
        logic [DIM_W-1:0] rows_reg;
        logic [DIM_W-1:0] cols_reg;
        logic [3:0]       walls [CELLS];
        path_beat_t       beats_due [$];
        int               errors;

        function void clear_all();
            rows_reg = 4'd8;
            cols_reg = 4'd8;
            foreach (walls[i])
                walls[i] = 4'b0;
            beats_due.delete();
            errors = 0;
        endfunction

        function void write_reg(logic idx, logic [DIM_W-1:0] value);
            if (idx == CFG_ROWS)
                rows_reg = value;
            else
                cols_reg = value;
        endfunction

        function void dims(output int r, output int c);
            r = rows_reg;
            c = cols_reg;
            if (r < 1) r = 1;
            if (r > MAX_ROWS) r = MAX_ROWS;
            if (c < 1) c = 1;
            if (c > MAX_COLS) c = MAX_COLS;
            if (r * c > CELLS)
                r = (CELLS / c < 1) ? 1 : CELLS / c;
        endfunction

        function void queue_beat(path_beat_t b);
            beats_due.insert(beats_due.size(), b);
        endfunction

        // -1 when the move leaves the grid
        function int step_to(int src, logic [1:0] side, int r, int c);
            int row;
            int col;
            row = src / c;
            col = src % c;
            case (side)
                SIDE_UP:   return (row > 0) ? src - c : -1;
                SIDE_LEFT: return (col > 0) ? src - 1 : -1;
                SIDE_DOWN: return (row + 1 < r) ? src + c : -1;
                default:   return (col + 1 < c) ? src + 1 : -1;
            endcase
        endfunction

        function void note_command(logic [1:0] cmd, logic [CELL_W-1:0] wc, logic [1:0] ws,
                                   logic [CELL_W-1:0] sc, logic [CELL_W-1:0] gc);
            int         r;
            int         c;
            int         nb;
            int         depth;
            int         top;
            int         cur;
            logic [1:0] s;
            logic [1:0] opp;
            bit         ok;
            bit         seen [CELLS];
            int         trail [CELLS];
            int         tried [CELLS];
            path_beat_t b;
            dims(r, c);
            case (cmd)
                CMD_CLEAR:
                begin
                    foreach (walls[i])
                        walls[i] = 4'b0;
                end
                CMD_ADD:
                begin
                    if (wc < r * c)
                    begin
                        walls[wc][ws] = 1'b1;
                        nb = step_to(wc, ws, r, c);
                        opp = ws + 2'd2;
                        if (nb >= 0)
                            walls[nb][opp] = 1'b1;
                    end
                end
                CMD_SOLVE:
                begin
                    ok = 1'b0;
                    depth = 0;
                    foreach (seen[i])
                        seen[i] = 1'b0;
                    if (sc < r * c && gc < r * c)
                    begin
                        trail[0] = sc;
                        tried[0] = 0;
                        seen[sc] = 1'b1;
                        depth = 1;
                        while (depth > 0 && !ok)
                        begin
                            top = depth - 1;
                            cur = trail[top];
                            if (cur == gc)
                                ok = 1'b1;
                            else if (tried[top] < 4)
                            begin
                                s = 2'(tried[top]);
                                tried[top]++;
                                if (!walls[cur][s])
                                begin
                                    nb = step_to(cur, s, r, c);
                                    if (nb >= 0 && !seen[nb])
                                    begin
                                        seen[nb] = 1'b1;
                                        trail[depth] = nb;
                                        tried[depth] = 0;
                                        depth++;
                                    end
                                end
                            end
                            else
                                depth--;
                        end
                    end
                    if (ok)
                    begin
                        for (int k = 0; k < depth; k++)
                        begin
                            b.cell_id = CELL_W'(trail[k]);
                            b.found = 1'b1;
                            b.last = (k == depth - 1);
                            queue_beat(b);
                        end
                    end
                    else
                    begin
                        b.cell_id = '0;
                        b.found = 1'b0;
                        b.last = 1'b1;
                        queue_beat(b);
                    end
                end
                default: ;
            endcase
        endfunction

        function void check_beat(logic [CELL_W-1:0] got_cell, logic fnd, logic lst);
            path_beat_t want;
            if (beats_due.size() == 0)
            begin
                errors++;
                if (errors <= 10)
                    $display("unexpected beat: cell %0d found %0b last %0b",
                             got_cell, fnd, lst);
            end
            else
            begin
                want = beats_due.pop_front();
                if (want.cell_id !== got_cell || want.found !== fnd || want.last !== lst)
                begin
                    errors++;
                    if (errors <= 10)
                        $display("mismatch: expected cell %0d found %0b last %0b, got %0d %0b %0b",
                                 want.cell_id, want.found, want.last, got_cell, fnd, lst);
                end
            end
        endfunction

        function void close_out();
            if (beats_due.size() != 0)
            begin
                if (errors < 10)
                    $display("%0d path beats never arrived", beats_due.size());
                errors += beats_due.size();
            end
        endfunction
    endclass

    logic              clk = 1'b0;
    logic              rst_n = 1'b0;
    logic              start = 1'b0;
    logic              busy;
    logic [1:0]        command = CMD_CLEAR;
    logic [CELL_W-1:0] wall_cell = '0;
    logic [1:0]        wall_side = SIDE_UP;
    logic [CELL_W-1:0] start_cell = '0;
    logic [CELL_W-1:0] goal_cell = '0;
    logic              cfg_write = 1'b0;
    logic              cfg_index = CFG_ROWS;
    logic [DIM_W-1:0]  cfg_data = '0;
    logic              result_valid;
    logic [CELL_W-1:0] path_cell;
    logic              found;
    logic              last;

    path_scoreboard sb;
    bit             start_high = 1'b0;
    int             burst_left = 4;
    int             phase_rows [7] = '{8, 4, 1, 8, 15, 0, 6};
    int             phase_cols [7] = '{8, 4, 8, 1, 15, 0, 5};

    grid_maze_dfs_solver dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .busy         (busy),
        .command      (command),
        .wall_cell    (wall_cell),
        .wall_side    (wall_side),
        .start_cell   (start_cell),
        .goal_cell    (goal_cell),
        .cfg_write    (cfg_write),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .result_valid (result_valid),
        .path_cell    (path_cell),
        .found        (found),
        .last         (last)
    );

    always #5 clk = ~clk;

    always @(posedge clk)
    begin
        if (rst_n && result_valid && sb != null)
            sb.check_beat(path_cell, found, last);
    end

    task automatic lower_start();
        if (start_high)
        begin
            start <= 1'b0;
            start_high = 1'b0;
        end
    endtask

    task automatic send_command(input logic [1:0] cmd, input logic [CELL_W-1:0] wc,
                                input logic [1:0] ws, input logic [CELL_W-1:0] sc,
                                input logic [CELL_W-1:0] gc);
        start <= 1'b1;
        start_high = 1'b1;
        command <= cmd;
        wall_cell <= wc;
        wall_side <= ws;
        start_cell <= sc;
        goal_cell <= gc;
        do
            @(posedge clk);
        while (busy);
        sb.note_command(cmd, wc, ws, sc, gc);
        burst_left--;
        if (burst_left <= 0)
        begin
            lower_start();
            repeat ($urandom_range(1, 12)) @(posedge clk);
            burst_left = $urandom_range(1, 40);
        end
    endtask

    task automatic do_solve(input int sc, input int gc);
        send_command(CMD_SOLVE, CELL_W'($urandom), 2'($urandom), CELL_W'(sc), CELL_W'(gc));
    endtask

    task automatic do_wall(input int pos, input logic [1:0] side);
        send_command(CMD_ADD, CELL_W'(pos), side, CELL_W'($urandom), CELL_W'($urandom));
    endtask

    // add wall may still be in flight once the queue is empty
    task automatic wait_drained();
        lower_start();
        while (sb.beats_due.size() != 0)
            @(posedge clk);
        repeat (20) @(posedge clk);
        while (busy)
            @(posedge clk);
    endtask

    task automatic set_reg(input logic idx, input logic [DIM_W-1:0] value);
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data <= value;
        @(posedge clk);
        sb.write_reg(idx, value);
        cfg_write <= 1'b0;
        @(posedge clk);
    endtask

    function automatic logic [CELL_W-1:0] pick_cell(input int n);
        if ($urandom_range(0, 9) == 0)
            return CELL_W'($urandom_range(0, CELLS - 1));
        return CELL_W'($urandom_range(0, n - 1));
    endfunction

    task automatic random_command();
        int         r;
        int         c;
        int         sel;
        logic [1:0] cmd;
        sb.dims(r, c);
        sel = $urandom_range(0, 99);
        if (sel < 3)
            cmd = CMD_CLEAR;
        else if (sel < 6)
            cmd = CMD_NONE;
        else if (sel < 52)
            cmd = CMD_ADD;
        else
            cmd = CMD_SOLVE;
        send_command(cmd, pick_cell(r * c), 2'($urandom_range(0, 3)),
                     pick_cell(r * c), pick_cell(r * c));
    endtask

    initial
    begin
        #20_000_000;
        $display("FAIL grid_maze_dfs_solver");
        $finish;
    end

    initial
    begin
        logic [DIM_W-1:0] rv;
        logic [DIM_W-1:0] cv;
        sb = new();
        sb.clear_all();
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;

        do_solve(0, 63);
        do_solve(27, 27);
        send_command(CMD_NONE, CELL_W'($urandom), 2'($urandom), CELL_W'($urandom),
                     CELL_W'($urandom));
        do_wall(0, SIDE_UP);
        do_wall(0, SIDE_RIGHT);
        do_wall(8, SIDE_UP);
        do_solve(0, 63);
        do_wall(63, SIDE_DOWN);
        do_wall(63, SIDE_LEFT);
        do_wall(55, SIDE_RIGHT);
        do_solve(62, 7);
        do_wall(36, SIDE_UP);
        do_wall(36, SIDE_LEFT);
        do_wall(36, SIDE_DOWN);
        do_solve(36, 0);
        do_solve(63, 36);
        send_command(CMD_CLEAR, CELL_W'($urandom), 2'($urandom), CELL_W'($urandom),
                     CELL_W'($urandom));
        do_solve(0, 63);

        wait_drained();
        set_reg(CFG_ROWS, 4'd1);
        set_reg(CFG_COLS, 4'd1);
        do_solve(0, 0);
        do_solve(0, 1);
        do_solve(40, 0);
        do_wall(3, SIDE_DOWN);

        wait_drained();
        set_reg(CFG_ROWS, 4'd0);
        set_reg(CFG_COLS, 4'd15);
        do_wall(3, SIDE_RIGHT);
        do_solve(0, 7);
        do_solve(0, 8);

        wait_drained();
        set_reg(CFG_ROWS, 4'd15);
        set_reg(CFG_COLS, 4'd3);
        do_solve(0, 23);
        do_solve(23, 0);

        for (int ph = 0; ph < 9; ph++)
        begin
            wait_drained();
            rv = (ph < 7) ? DIM_W'(phase_rows[ph]) : DIM_W'($urandom_range(0, 15));
            cv = (ph < 7) ? DIM_W'(phase_cols[ph]) : DIM_W'($urandom_range(0, 15));
            set_reg(CFG_ROWS, rv);
            set_reg(CFG_COLS, cv);
            if ($urandom_range(0, 1))
                send_command(CMD_CLEAR, CELL_W'($urandom), 2'($urandom), CELL_W'($urandom),
                             CELL_W'($urandom));
            for (int k = 0; k < 36; k++)
            begin
                random_command();
                if ($urandom_range(0, 49) == 0)
                    wait_drained();
            end
        end

        wait_drained();
        repeat (200) @(posedge clk);
        sb.close_out();
        if (sb.errors == 0)
            $display("PASS grid_maze_dfs_solver");
        else
            $display("FAIL grid_maze_dfs_solver");
        $finish;
    end

endmodule
